>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SPE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/spe_pkg.sv
package spe_pkg;

   localparam int SPE_MAX_STEPS = 16;

   // operations
   localparam logic [3:0] OP_ACCEPT     = 4'd0;
   localparam logic [3:0] OP_DISP_OK    = 4'd1;
   localparam logic [3:0] OP_DISP_FAIL  = 4'd2;
   localparam logic [3:0] OP_TERMINAL   = 4'd3;
   localparam logic [3:0] OP_TIMEOUT    = 4'd4;
   localparam logic [3:0] OP_SKIP       = 4'd5;
   localparam logic [3:0] OP_CANCEL     = 4'd6;
   localparam logic [3:0] OP_ABORT      = 4'd7;
   localparam logic [3:0] OP_FAULT_ACK  = 4'd8;
   localparam logic [3:0] OP_LOAD_OK    = 4'd9;
   localparam logic [3:0] OP_UNLOAD_OK  = 4'd10;
   localparam logic [3:0] OP_LOAD_STEP  = 4'd11;

   // phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_DISP    = 3'd1;
   localparam logic [2:0] PH_ACTIVE  = 3'd2;
   localparam logic [2:0] PH_CANCEL  = 3'd3;
   localparam logic [2:0] PH_RESET   = 3'd4;
   localparam logic [2:0] PH_WLOAD   = 3'd5;
   localparam logic [2:0] PH_WUNLOAD = 3'd6;
   localparam logic [2:0] PH_FAULT   = 3'd7;

   // last-event codes
   localparam logic [3:0] EV_NONE       = 4'd0;
   localparam logic [3:0] EV_DISPATCHED = 4'd1;
   localparam logic [3:0] EV_TERMINAL   = 4'd2;
   localparam logic [3:0] EV_COMPLETE   = 4'd3;
   localparam logic [3:0] EV_SKIPPED    = 4'd4;
   localparam logic [3:0] EV_TIMEOUT    = 4'd5;
   localparam logic [3:0] EV_CANCELLED  = 4'd6;
   localparam logic [3:0] EV_ABORTED    = 4'd7;
   localparam logic [3:0] EV_FAULT      = 4'd8;
   localparam logic [3:0] EV_RESET_DONE = 4'd9;
   localparam logic [3:0] EV_ACCEPTED   = 4'd10;

   // commands
   localparam logic [2:0] CMD_DISPATCH = 3'd0;
   localparam logic [2:0] CMD_TERMINAL = 3'd1;
   localparam logic [2:0] CMD_FAULT    = 3'd2;
   localparam logic [2:0] CMD_CANCEL   = 3'd3;
   localparam logic [2:0] CMD_RESET    = 3'd4;
   localparam logic [2:0] CMD_IDLE     = 3'd5;

   // token kinds and slots
   localparam logic [1:0] TK_NORMAL = 2'd0;
   localparam logic [1:0] TK_CANACK = 2'd1;
   localparam logic [1:0] TK_RSTACK = 2'd2;
   localparam int TS_ACT = 0;
   localparam int TS_CAN = 1;
   localparam int TS_RST = 2;

   // step kinds
   localparam logic [7:0] SK_WLOAD   = 8'd0;
   localparam logic [7:0] SK_WUNLOAD = 8'd1;
   localparam logic [7:0] SK_FINISH  = 8'd2;
   localparam logic [7:0] SK_UV      = 8'd3;

   // outcomes
   localparam logic [1:0] OC_COMPLETE = 2'd0;
   localparam logic [1:0] OC_FAULT    = 2'd1;
   localparam logic [1:0] OC_ABORTED  = 2'd2;
   localparam logic [1:0] OC_CANCELED = 2'd3;

   localparam logic [15:0] ERR_DISPATCH = 16'd100;
   localparam logic [15:0] ERR_SERVICE  = 16'd200;
   localparam logic [15:0] ERR_CANCEL   = 16'd300;
   localparam logic [15:0] ERR_RESET    = 16'd400;
   localparam logic [15:0] ERR_REJECT   = 16'd1;

   localparam logic [3:0] CSR_STEP_COUNT = 4'd0;
   localparam logic [3:0] CSR_QUIESCE    = 4'd1;

   typedef struct packed {
      logic [3:0]  operation;
      logic [15:0] prog_ident;
      logic [15:0] gen_in;
      logic [15:0] step_ident;
      logic [15:0] req_in;
      logic [7:0]  kind_in;
      logic [1:0]  token_kind_in;
      logic        ok_in;
      logic [15:0] err_in;
      logic [3:0]  slot;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  cmd_kind;
      logic [15:0] prog_out;
      logic [15:0] gen_out;
      logic [15:0] step_out;
      logic [15:0] req_out;
      logic [7:0]  kind_out;
      logic [1:0]  token_kind_out;
      logic        ok_out;
      logic [15:0] err_out;
      logic [1:0]  outcome;
      logic        pos_confirmed;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0]  addr;
      logic [15:0] wdata;
   } csr_item_type;

   typedef struct packed {
      logic [15:0] prog;
      logic [15:0] gen;
      logic [15:0] step;
      logic [15:0] req;
      logic [7:0]  kind;
      logic [1:0]  tkind;
   } tok_type;

   function automatic logic [15:0] inc_nz(input logic [15:0] v);
      logic [15:0] s;
      s = v + 16'd1;
      return (s == 16'd0) ? 16'd1 : s;
   endfunction

   function automatic rsp_item_type make_rsp(input logic [2:0] cmd, input tok_type t,
                                             input logic use_t, input logic [15:0] prog,
                                             input logic ok, input logic [15:0] err,
                                             input logic [1:0] oc, input logic pos);
      rsp_item_type r;
      r.cmd_kind       = cmd;
      r.prog_out       = use_t ? t.prog : prog;
      r.gen_out        = use_t ? t.gen : 16'd0;
      r.step_out       = use_t ? t.step : 16'd0;
      r.req_out        = use_t ? t.req : 16'd0;
      r.kind_out       = use_t ? t.kind : 8'd0;
      r.token_kind_out = use_t ? t.tkind : 2'd0;
      r.ok_out         = ok;
      r.err_out        = err;
      r.outcome        = oc;
      r.pos_confirmed  = pos;
      r.last           = 1'b0;
      return r;
   endfunction

endpackage

>>> rtl/spe_req_if.sv
interface spe_req_if import spe_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/spe_rsp_if.sv
interface spe_rsp_if import spe_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/spe_csr_if.sv
interface spe_csr_if import spe_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/spe_out_queue.sv
module spe_out_queue import spe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [1:0]   push_n,
   input  rsp_item_type push_a,
   input  rsp_item_type push_b,
   output logic         can_push,
   output logic         out_valid,
   output rsp_item_type out_data,
   input  logic         out_ready
);
   rsp_item_type q0_ff, q1_ff;
   logic [1:0]   cnt_ff;
   logic         pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = q0_ff;
   assign pop       = out_valid && out_ready;
   // push only when the queue is empty or drains completely this cycle
   assign can_push  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (push) begin
         cnt_ff <= push_n;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q0_ff <= push_a;
         q1_ff <= push_b;
      end else if (pop) begin
         q0_ff <= q1_ff;
      end
   end
endmodule

>>> rtl/step_program_executor_core.sv
// Path: a word is held in the input register, and its first command is registered
// in the output queue before it appears on rsp; a fault's second command follows it.
// Rate: one word per cycle while each yields at most one command and rsp is ready;
// a two-command word holds the next word in the input register as the output queue drains.
// Reset: synchronous, clears phase, tokens and queue, sets counters to start values; step table is not cleared.
`include "assert_macros.svh"
module step_program_executor_core import spe_pkg::*; #(
   parameter int MAX_STEPS = SPE_MAX_STEPS
) (
   input logic      clock,
   input logic      reset,
   spe_req_if.sink  req_chan,
   spe_rsp_if.source rsp_chan,
   spe_csr_if.sink  csr_chan
);
   localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam logic [8:0] MAX9 = MAX_STEPS[8:0];

   req_item_type in_ff;
   logic         in_vld_ff;
   logic         fire, can_push;

   logic [4:0]  step_count_ff;
   logic        quiesce_ff;
   logic [2:0]  ph_ff;
   logic        run_ff, flt_ff, skip_ff;
   logic [4:0]  pos_ff;
   logic [15:0] gen_ff, reqc_ff, cur_ff;
   logic [3:0]  prior_ff;
   tok_type     tok_ff [3];
   logic [2:0]  vld_ff;

   logic [15:0] tbl_id_ff [MAX_STEPS];
   logic [7:0]  tbl_kind_ff [MAX_STEPS];

   logic [2:0]  ph_in;
   logic        run_in, flt_in, skip_in;
   logic [4:0]  pos_in;
   logic [15:0] gen_in, reqc_in, cur_in;
   logic [3:0]  prior_in;
   tok_type     tok_in [3];
   logic [2:0]  vld_in;
   rsp_item_type r0, r1;
   logic [1:0]  nres;

   logic [4:0]  effc, rd_addr;
   logic [8:0]  rd9, slot9;
   logic [15:0] tid;
   logic [7:0]  tk;
   logic        adv_pred, hs_cur;
   tok_type     tin, tzero;

   assign req_chan.ready = !in_vld_ff || fire;
   assign fire = in_vld_ff && can_push;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_ff <= req_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= 5'd0;
         quiesce_ff    <= 1'b0;
      end else if (csr_chan.valid) begin
         if (csr_chan.data.addr == CSR_STEP_COUNT) begin
            step_count_ff <= csr_chan.data.wdata[4:0];
         end else if (csr_chan.data.addr == CSR_QUIESCE) begin
            quiesce_ff <= csr_chan.data.wdata[0];
         end
      end
   end

   assign effc = ({4'd0, step_count_ff} > MAX9) ? MAX9[4:0] : step_count_ff;
   assign hs_cur = pos_ff < effc;

   // one table read: the step the event will look at
   always_comb begin
      adv_pred = ((in_ff.operation == OP_LOAD_OK) && (ph_ff == PH_WLOAD)) ||
                 ((in_ff.operation == OP_UNLOAD_OK) && (ph_ff == PH_WUNLOAD)) ||
                 ((in_ff.operation == OP_TERMINAL) && in_ff.ok_in &&
                  (((ph_ff == PH_CANCEL) && skip_ff) || (ph_ff == PH_ACTIVE)));
      if (in_ff.operation == OP_ACCEPT) begin
         rd_addr = 5'd0;
      end else if (adv_pred) begin
         rd_addr = pos_ff + 5'd1;
      end else begin
         rd_addr = pos_ff;
      end
   end
   assign rd9 = {4'd0, rd_addr};
   assign tid = tbl_id_ff[rd9[IW-1:0]];
   assign tk  = tbl_kind_ff[rd9[IW-1:0]];
   assign slot9 = {5'd0, in_ff.slot};

   always_ff @(posedge clock) begin
      if (fire && (in_ff.operation == OP_LOAD_STEP) && (slot9 < MAX9)) begin
         tbl_id_ff[slot9[IW-1:0]]   <= in_ff.step_ident;
         tbl_kind_ff[slot9[IW-1:0]] <= in_ff.kind_in;
      end
   end

   assign tin = '{prog: in_ff.prog_ident, gen: in_ff.gen_in, step: in_ff.step_ident,
                  req: in_ff.req_in, kind: in_ff.kind_in, tkind: in_ff.token_kind_in};
   assign tzero = '0;

   always_comb begin
      logic        do_nof, nof_cmpl, do_fault;
      logic [15:0] fcode;
      tok_type     tc;
      ph_in = ph_ff; run_in = run_ff; flt_in = flt_ff; skip_in = skip_ff;
      pos_in = pos_ff; gen_in = gen_ff; reqc_in = reqc_ff; cur_in = cur_ff;
      prior_in = prior_ff; tok_in = tok_ff; vld_in = vld_ff;
      r0 = '0; r1 = '0; nres = 2'd0;
      do_nof = 1'b0; nof_cmpl = 1'b0; do_fault = 1'b0; fcode = 16'd0;
      tc = tok_ff[TS_ACT];
      tc.tkind = TK_CANACK;

      unique case (in_ff.operation)
         OP_ACCEPT: begin
            if (ph_ff != PH_IDLE || run_ff || flt_ff || quiesce_ff) begin
               r0 = make_rsp(CMD_TERMINAL, tzero, 1'b0, 16'd0, 1'b0, ERR_REJECT,
                             OC_FAULT, 1'b0);
               nres = 2'd1;
            end else begin
               cur_in = in_ff.prog_ident; skip_in = 1'b0; run_in = 1'b1;
               pos_in = 5'd0; gen_in = inc_nz(gen_ff); prior_in = EV_ACCEPTED;
               do_nof = 1'b1; nof_cmpl = 1'b1;
            end
         end
         OP_DISP_OK: begin
            if (ph_ff == PH_DISP) begin
               ph_in = PH_ACTIVE;
               if (run_ff && hs_cur && tk == SK_UV) prior_in = EV_DISPATCHED;
            end
         end
         OP_DISP_FAIL: begin
            if (ph_ff == PH_DISP) begin
               do_fault = 1'b1; fcode = ERR_DISPATCH;
            end
         end
         OP_TERMINAL: begin
            if (ph_ff == PH_CANCEL) begin
               if (vld_ff[TS_CAN] && in_ff.token_kind_in == TK_CANACK &&
                   tin == tok_ff[TS_CAN]) begin
                  vld_in[TS_CAN] = 1'b0;
                  if (in_ff.ok_in && skip_ff) begin
                     skip_in = 1'b0; prior_in = EV_SKIPPED;
                     pos_in = pos_ff + 5'd1; vld_in[TS_ACT] = 1'b0;
                     tok_in[TS_ACT] = '0;
                     do_nof = 1'b1;
                  end else if (in_ff.ok_in) begin
                     ph_in = PH_RESET;
                     tok_in[TS_RST] = '{prog: cur_ff, gen: gen_ff,
                                        step: hs_cur ? tid : 16'd0, req: reqc_ff,
                                        kind: hs_cur ? tk : 8'd0, tkind: TK_RSTACK};
                     reqc_in = inc_nz(reqc_ff);
                     vld_in[TS_RST] = 1'b1;
                     r0 = make_rsp(CMD_RESET, tok_in[TS_RST], 1'b1, 16'd0, 1'b0, 16'd0,
                                   OC_COMPLETE, 1'b0);
                     nres = 2'd1;
                     prior_in = EV_TERMINAL;
                  end else begin
                     skip_in = 1'b0; do_fault = 1'b1;
                     fcode = (in_ff.err_in != 16'd0) ? in_ff.err_in : ERR_CANCEL;
                  end
               end
            end else if (ph_ff == PH_ACTIVE) begin
               if (vld_ff[TS_ACT] && in_ff.token_kind_in == TK_NORMAL &&
                   tin == tok_ff[TS_ACT]) begin
                  vld_in[TS_ACT] = 1'b0;
                  if (in_ff.ok_in) begin
                     prior_in = EV_TERMINAL;
                     pos_in = pos_ff + 5'd1; tok_in[TS_ACT] = '0;
                     do_nof = 1'b1; nof_cmpl = 1'b1;
                  end else begin
                     do_fault = 1'b1;
                     fcode = (in_ff.err_in != 16'd0) ? in_ff.err_in : ERR_SERVICE;
                  end
               end
            end else if (ph_ff == PH_RESET) begin
               if (vld_ff[TS_RST] && in_ff.token_kind_in == TK_RSTACK &&
                   tin == tok_ff[TS_RST]) begin
                  vld_in[TS_RST] = 1'b0;
                  if (in_ff.ok_in) begin
                     run_in = 1'b0;
                     r0 = make_rsp(CMD_TERMINAL, tzero, 1'b0, cur_ff, 1'b0, 16'd0,
                                   (prior_ff == EV_ABORTED) ? OC_ABORTED : OC_CANCELED,
                                   1'b1);
                     nres = 2'd1;
                     prior_in = EV_RESET_DONE; ph_in = PH_IDLE;
                  end else begin
                     do_fault = 1'b1; fcode = ERR_RESET;
                  end
               end
            end
         end
         OP_TIMEOUT, OP_SKIP, OP_CANCEL, OP_ABORT: begin
            if ((in_ff.operation == OP_TIMEOUT && ph_ff == PH_ACTIVE) ||
                (in_ff.operation == OP_SKIP && run_ff && ph_ff == PH_ACTIVE &&
                 vld_ff[TS_ACT] && hs_cur && tk == SK_UV) ||
                (in_ff.operation == OP_CANCEL &&
                 (ph_ff == PH_ACTIVE || ph_ff == PH_DISP)) ||
                (in_ff.operation == OP_ABORT && run_ff && ph_ff != PH_CANCEL &&
                 ph_ff != PH_RESET)) begin
               // timeout always cancels; others only with a live service token
               if ((ph_ff == PH_ACTIVE || ph_ff == PH_DISP) &&
                   (vld_ff[TS_ACT] || in_ff.operation == OP_TIMEOUT)) begin
                  tok_in[TS_CAN] = tc;
                  vld_in[TS_CAN] = 1'b1;
                  r0 = make_rsp(CMD_CANCEL, tc, 1'b1, 16'd0, 1'b0, 16'd0,
                                OC_COMPLETE, 1'b0);
                  nres = 2'd1;
               end
               if (ph_ff == PH_ACTIVE || ph_ff == PH_DISP) vld_in[TS_ACT] = 1'b0;
               skip_in = (in_ff.operation == OP_SKIP);
               ph_in = PH_CANCEL;
               unique case (in_ff.operation)
                  OP_TIMEOUT: prior_in = EV_TIMEOUT;
                  OP_SKIP:    prior_in = EV_SKIPPED;
                  OP_CANCEL:  prior_in = EV_CANCELLED;
                  default:    prior_in = EV_ABORTED;
               endcase
            end
         end
         OP_FAULT_ACK: begin
            if (ph_ff == PH_FAULT) begin
               flt_in = 1'b0; run_in = 1'b0; vld_in = 3'b000;
               r0 = make_rsp(CMD_IDLE, tzero, 1'b0, 16'd0, 1'b0, 16'd0,
                             OC_COMPLETE, 1'b0);
               nres = 2'd1;
               ph_in = PH_IDLE;
            end
         end
         OP_LOAD_OK, OP_UNLOAD_OK: begin
            if ((in_ff.operation == OP_LOAD_OK && ph_ff == PH_WLOAD) ||
                (in_ff.operation == OP_UNLOAD_OK && ph_ff == PH_WUNLOAD)) begin
               pos_in = pos_ff + 5'd1; vld_in[TS_ACT] = 1'b0; tok_in[TS_ACT] = '0;
               do_nof = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (do_fault) begin
         flt_in = 1'b1; run_in = 1'b0;
         r0 = make_rsp(CMD_FAULT, tzero, 1'b0, 16'd0, 1'b0, fcode, OC_FAULT, 1'b0);
         r1 = make_rsp(CMD_TERMINAL, tzero, 1'b0, cur_ff, 1'b0, fcode, OC_FAULT, 1'b0);
         nres = 2'd2;
         prior_in = EV_FAULT; ph_in = PH_FAULT;
      end

      // next step or finish; table data here is for pos_in
      if (do_nof) begin
         if (!(pos_in < effc)) begin
            run_in = 1'b0;
            r0 = make_rsp(CMD_TERMINAL, tzero, 1'b0, cur_in, 1'b1, 16'd0,
                          OC_COMPLETE, 1'b1);
            nres = 2'd1;
            ph_in = PH_IDLE;
            if (nof_cmpl) prior_in = EV_COMPLETE;
         end else if (run_in) begin
            if (tk == SK_WLOAD) begin
               ph_in = PH_WLOAD; prior_in = EV_DISPATCHED;
            end else if (tk == SK_WUNLOAD) begin
               ph_in = PH_WUNLOAD; prior_in = EV_DISPATCHED;
            end else if (tk == SK_FINISH) begin
               pos_in = pos_in + 5'd1; vld_in[TS_ACT] = 1'b0; tok_in[TS_ACT] = '0;
               run_in = 1'b0;
               r0 = make_rsp(CMD_TERMINAL, tzero, 1'b0, cur_in, 1'b1, 16'd0,
                             OC_COMPLETE, 1'b1);
               nres = 2'd1;
               ph_in = PH_IDLE; prior_in = EV_COMPLETE;
            end else begin
               tok_in[TS_ACT] = '{prog: cur_in, gen: gen_in, step: tid, req: reqc_in,
                                  kind: tk, tkind: TK_NORMAL};
               reqc_in = inc_nz(reqc_in);
               vld_in[TS_ACT] = 1'b1;
               ph_in = PH_DISP;
               r0 = make_rsp(CMD_DISPATCH, tok_in[TS_ACT], 1'b1, cur_in, 1'b0, 16'd0,
                             OC_COMPLETE, 1'b0);
               nres = 2'd1;
               prior_in = EV_DISPATCHED;
            end
         end
      end

      if (nres == 2'd1) r0.last = 1'b1;
      if (nres == 2'd2) r1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; run_ff <= 1'b0; flt_ff <= 1'b0; skip_ff <= 1'b0;
         pos_ff <= 5'd0; gen_ff <= 16'd0; reqc_ff <= 16'd1; cur_ff <= 16'd0;
         prior_ff <= EV_NONE; vld_ff <= 3'b000;
         tok_ff[0] <= '0; tok_ff[1] <= '0; tok_ff[2] <= '0;
      end else if (fire) begin
         ph_ff <= ph_in; run_ff <= run_in; flt_ff <= flt_in; skip_ff <= skip_in;
         pos_ff <= pos_in; gen_ff <= gen_in; reqc_ff <= reqc_in; cur_ff <= cur_in;
         prior_ff <= prior_in; vld_ff <= vld_in;
         tok_ff[0] <= tok_in[0]; tok_ff[1] <= tok_in[1]; tok_ff[2] <= tok_in[2];
      end
   end

   spe_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_n    (nres),
      .push_a    (r0),
      .push_b    (r1),
      .can_push  (can_push),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_chan.data),
      .out_ready (rsp_chan.ready)
   );

   `SPE_ASSERT_IMPL(a_fault_flag, clock, reset, ph_ff == PH_FAULT, flt_ff)
   `SPE_ASSERT_IMPL(a_idle_stopped, clock, reset, ph_ff == PH_IDLE, !run_ff)
   `SPE_ASSERT_IMPL(a_rst_tok_phase, clock, reset, vld_ff[TS_RST], ph_ff == PH_RESET)
   `SPE_ASSERT_NEXT(a_pair_out, clock, reset, fire && nres == 2'd2, rsp_chan.valid)
endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import spe_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   // Expected commands, checked in order of arrival.
   class cmd_scoreboard;
      rsp_item_type pending[$];

      function void note_word(rsp_item_type due[$]);
         foreach (due[i]) pending.push_back(due[i]);
      endfunction

      function string check_cmd(rsp_item_type got);
         rsp_item_type want;
         string why;
         why = "";
         if (pending.size() == 0)
            return $sformatf("unexpected command %h", got);
         want = pending.pop_front();
         if (got.cmd_kind != want.cmd_kind) why = {why, " cmd_kind"};
         if (got.prog_out != want.prog_out) why = {why, " prog_out"};
         if (got.gen_out != want.gen_out) why = {why, " gen_out"};
         if (got.step_out != want.step_out) why = {why, " step_out"};
         if (got.req_out != want.req_out) why = {why, " req_out"};
         if (got.kind_out != want.kind_out) why = {why, " kind_out"};
         if (got.token_kind_out != want.token_kind_out) why = {why, " token_kind_out"};
         if (got.ok_out != want.ok_out) why = {why, " ok_out"};
         if (got.err_out != want.err_out) why = {why, " err_out"};
         if (got.outcome != want.outcome) why = {why, " outcome"};
         if (got.pos_confirmed != want.pos_confirmed) why = {why, " pos_confirmed"};
         if (got.last != want.last) why = {why, " last"};
         if (why != "")
            return $sformatf("field%s: got %h want %h", why, got, want);
         return "";
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   spe_req_if req ();
   spe_rsp_if rsp ();
   spe_csr_if csr ();

   step_program_executor_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   always #4 clock = ~clock;

   cmd_scoreboard sb = new();
   int fails = 0;
   int send_idle = 0;
   int rsp_stall = 0;
   bit req_up = 0;
   int quiet_cycles = 0;

   // executor state as predicted
   logic [4:0]  cfg_count = '0;
   logic        cfg_quiesce = 1'b0;
   logic [2:0]  exec_phase = PH_IDLE;
   logic        running = 1'b0;
   logic        faulted = 1'b0;
   logic [15:0] fault_val = '0;
   logic [4:0]  step_pos = '0;
   logic [4:0]  steps_done = '0;
   logic [15:0] gen_count = '0;
   logic [15:0] req_count = 16'd1;
   logic [15:0] cur_prog = '0;
   logic        skip_pending = 1'b0;
   logic [3:0]  prior_ev = EV_NONE;
   tok_type     tokens [3];
   logic [2:0]  tok_valid = '0;
   logic [15:0] tbl_id [SPE_MAX_STEPS];
   logic [7:0]  tbl_kind [SPE_MAX_STEPS];
   rsp_item_type cmds_due[$];

   task automatic report(string msg);
      if (fails < 40) $display("tb: mismatch: %s", msg);
      fails++;
   endtask

   function automatic int eff_count();
      return (cfg_count > SPE_MAX_STEPS) ? SPE_MAX_STEPS : int'(cfg_count);
   endfunction

   function automatic bit has_step();
      return int'(step_pos) < eff_count();
   endfunction

   function automatic req_item_type rand_word();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_item_type)-1:0];
   endfunction

   function automatic void push_cmd(logic [2:0] kind, tok_type t, bit use_t, logic [15:0] prog,
                                    bit ok, logic [15:0] err, logic [1:0] oc, bit pos);
      rsp_item_type r;
      if (cmds_due.size() >= 2) return;
      r.cmd_kind       = kind;
      r.prog_out       = use_t ? t.prog : prog;
      r.gen_out        = use_t ? t.gen : '0;
      r.step_out       = use_t ? t.step : '0;
      r.req_out        = use_t ? t.req : '0;
      r.kind_out       = use_t ? t.kind : '0;
      r.token_kind_out = use_t ? t.tkind : '0;
      r.ok_out         = ok;
      r.err_out        = err;
      r.outcome        = oc;
      r.pos_confirmed  = pos;
      r.last           = 1'b0;
      cmds_due.push_back(r);
   endfunction

   function automatic logic [15:0] take_req_id();
      logic [15:0] id;
      id = req_count;
      req_count = req_count + 16'd1;
      if (req_count == 0) req_count = 16'd1;
      return id;
   endfunction

   function automatic tok_type make_token(logic [15:0] rid, logic [1:0] tk);
      tok_type t;
      t = '0;
      t.prog = cur_prog;
      t.gen = gen_count;
      if (has_step()) begin
         t.step = tbl_id[step_pos];
         t.kind = tbl_kind[step_pos];
      end
      t.req = rid;
      t.tkind = tk;
      return t;
   endfunction

   function automatic void advance_step();
      steps_done = steps_done + 5'd1;
      step_pos = step_pos + 5'd1;
      tok_valid[TS_ACT] = 1'b0;
      tokens[TS_ACT] = '0;
   endfunction

   function automatic void finish_ok();
      running = 1'b0;
      push_cmd(CMD_TERMINAL, '0, 0, cur_prog, 1, 16'd0, OC_COMPLETE, 1);
      exec_phase = PH_IDLE;
   endfunction

   function automatic void go_fault(logic [15:0] code);
      faulted = 1'b1;
      fault_val = code;
      running = 1'b0;
      push_cmd(CMD_FAULT, '0, 0, 16'd0, 0, code, OC_FAULT, 0);
      push_cmd(CMD_TERMINAL, '0, 0, cur_prog, 0, code, OC_FAULT, 0);
      prior_ev = EV_FAULT;
      exec_phase = PH_FAULT;
   endfunction

   function automatic void run_step();
      logic [7:0] k;
      if (!running || !has_step()) return;
      k = tbl_kind[step_pos];
      if (k == SK_WLOAD) begin
         exec_phase = PH_WLOAD;
         prior_ev = EV_DISPATCHED;
      end else if (k == SK_WUNLOAD) begin
         exec_phase = PH_WUNLOAD;
         prior_ev = EV_DISPATCHED;
      end else if (k == SK_FINISH) begin
         advance_step();
         finish_ok();
         prior_ev = EV_COMPLETE;
      end else begin
         tokens[TS_ACT] = make_token(take_req_id(), TK_NORMAL);
         tok_valid[TS_ACT] = 1'b1;
         exec_phase = PH_DISP;
         push_cmd(CMD_DISPATCH, tokens[TS_ACT], 1, cur_prog, 0, 16'd0, OC_COMPLETE, 0);
         prior_ev = EV_DISPATCHED;
      end
   endfunction

   function automatic void next_or_finish();
      if (has_step()) run_step();
      else finish_ok();
   endfunction

   function automatic bit token_hit(int which, logic [1:0] tk, tok_type t);
      if (!tok_valid[which] || t.tkind != tk) return 0;
      return tokens[which] == t;
   endfunction

   function automatic void send_cancel();
      tokens[TS_CAN] = tokens[TS_ACT];
      tokens[TS_CAN].tkind = TK_CANACK;
      tok_valid[TS_CAN] = 1'b1;
      push_cmd(CMD_CANCEL, tokens[TS_CAN], 1, 16'd0, 0, 16'd0, OC_COMPLETE, 0);
   endfunction

   function automatic void take_terminal(tok_type t, bit ok, logic [15:0] err);
      if (exec_phase == PH_CANCEL) begin
         if (!token_hit(TS_CAN, TK_CANACK, t)) return;
         tok_valid[TS_CAN] = 1'b0;
         if (ok && skip_pending) begin
            skip_pending = 1'b0;
            prior_ev = EV_SKIPPED;
            advance_step();
            next_or_finish();
         end else if (ok) begin
            exec_phase = PH_RESET;
            tokens[TS_RST] = make_token(take_req_id(), TK_RSTACK);
            tok_valid[TS_RST] = 1'b1;
            push_cmd(CMD_RESET, tokens[TS_RST], 1, 16'd0, 0, 16'd0, OC_COMPLETE, 0);
            prior_ev = EV_TERMINAL;
         end else begin
            skip_pending = 1'b0;
            go_fault(err != 0 ? err : ERR_CANCEL);
         end
      end else if (exec_phase == PH_ACTIVE) begin
         if (!token_hit(TS_ACT, TK_NORMAL, t)) return;
         tok_valid[TS_ACT] = 1'b0;
         if (ok) begin
            prior_ev = EV_TERMINAL;
            advance_step();
            if (has_step()) run_step();
            else begin
               finish_ok();
               prior_ev = EV_COMPLETE;
            end
         end else begin
            go_fault(err != 0 ? err : ERR_SERVICE);
         end
      end else if (exec_phase == PH_RESET) begin
         if (!token_hit(TS_RST, TK_RSTACK, t)) return;
         tok_valid[TS_RST] = 1'b0;
         if (ok) begin
            running = 1'b0;
            push_cmd(CMD_TERMINAL, '0, 0, cur_prog, 0, 16'd0,
                     prior_ev == EV_ABORTED ? OC_ABORTED : OC_CANCELED, 1);
            prior_ev = EV_RESET_DONE;
            exec_phase = PH_IDLE;
         end else begin
            go_fault(ERR_RESET);
         end
      end
   endfunction

   function automatic void predict_word(req_item_type w);
      tok_type t;
      t.prog = w.prog_ident;
      t.gen = w.gen_in;
      t.step = w.step_ident;
      t.req = w.req_in;
      t.kind = w.kind_in;
      t.tkind = w.token_kind_in;
      cmds_due.delete();
      case (w.operation)
         OP_ACCEPT: begin
            if (exec_phase != PH_IDLE || running || faulted || cfg_quiesce) begin
               push_cmd(CMD_TERMINAL, '0, 0, 16'd0, 0, ERR_REJECT, OC_FAULT, 0);
            end else begin
               cur_prog = w.prog_ident;
               skip_pending = 1'b0;
               running = 1'b1;
               step_pos = '0;
               steps_done = '0;
               gen_count = gen_count + 16'd1;
               if (gen_count == 0) gen_count = 16'd1;
               prior_ev = EV_ACCEPTED;
               if (eff_count() == 0) begin
                  finish_ok();
                  prior_ev = EV_COMPLETE;
               end else begin
                  run_step();
               end
            end
         end
         OP_DISP_OK: begin
            if (exec_phase == PH_DISP) begin
               exec_phase = PH_ACTIVE;
               if (running && has_step() && tbl_kind[step_pos] == SK_UV)
                  prior_ev = EV_DISPATCHED;
            end
         end
         OP_DISP_FAIL: if (exec_phase == PH_DISP) go_fault(ERR_DISPATCH);
         OP_TERMINAL: take_terminal(t, w.ok_in, w.err_in);
         OP_TIMEOUT: begin
            if (exec_phase == PH_ACTIVE) begin
               skip_pending = 1'b0;
               send_cancel();
               tok_valid[TS_ACT] = 1'b0;
               exec_phase = PH_CANCEL;
               prior_ev = EV_TIMEOUT;
            end
         end
         OP_SKIP: begin
            if (running && exec_phase == PH_ACTIVE && tok_valid[TS_ACT] && has_step() &&
                tbl_kind[step_pos] == SK_UV) begin
               send_cancel();
               tok_valid[TS_ACT] = 1'b0;
               skip_pending = 1'b1;
               exec_phase = PH_CANCEL;
               prior_ev = EV_SKIPPED;
            end
         end
         OP_CANCEL: begin
            if (exec_phase == PH_ACTIVE || exec_phase == PH_DISP) begin
               skip_pending = 1'b0;
               if (tok_valid[TS_ACT]) send_cancel();
               tok_valid[TS_ACT] = 1'b0;
               exec_phase = PH_CANCEL;
               prior_ev = EV_CANCELLED;
            end
         end
         OP_ABORT: begin
            if (running && exec_phase != PH_CANCEL && exec_phase != PH_RESET) begin
               skip_pending = 1'b0;
               if (exec_phase == PH_ACTIVE || exec_phase == PH_DISP) begin
                  if (tok_valid[TS_ACT]) send_cancel();
                  tok_valid[TS_ACT] = 1'b0;
               end
               exec_phase = PH_CANCEL;
               prior_ev = EV_ABORTED;
            end
         end
         OP_FAULT_ACK: begin
            if (exec_phase == PH_FAULT) begin
               faulted = 1'b0;
               fault_val = '0;
               running = 1'b0;
               tok_valid = '0;
               push_cmd(CMD_IDLE, '0, 0, 16'd0, 0, 16'd0, OC_COMPLETE, 0);
               exec_phase = PH_IDLE;
            end
         end
         OP_LOAD_OK: begin
            if (exec_phase == PH_WLOAD) begin
               advance_step();
               next_or_finish();
            end
         end
         OP_UNLOAD_OK: begin
            if (exec_phase == PH_WUNLOAD) begin
               advance_step();
               next_or_finish();
            end
         end
         OP_LOAD_STEP: begin
            if (int'(w.slot) < SPE_MAX_STEPS) begin
               tbl_id[w.slot] = w.step_ident;
               tbl_kind[w.slot] = w.kind_in;
            end
         end
         default: ;
      endcase
      if (cmds_due.size() > 0) cmds_due[cmds_due.size() - 1].last = 1'b1;
      sb.note_word(cmds_due);
   endfunction

   function automatic logic [7:0] pick_step_kind();
      case ($urandom_range(9))
         0, 1: return SK_WLOAD;
         2: return SK_WUNLOAD;
         3: return SK_FINISH;
         4, 5, 6: return SK_UV;
         default: return 8'($urandom_range(255, 4));
      endcase
   endfunction

   function automatic req_item_type terminal_for(tok_type k, req_item_type w);
      int b;
      w.operation = OP_TERMINAL;
      w.prog_ident = k.prog;
      w.gen_in = k.gen;
      w.step_ident = k.step;
      w.req_in = k.req;
      w.kind_in = k.kind;
      w.token_kind_in = k.tkind;
      w.ok_in = ($urandom_range(9) != 0);
      w.err_in = $urandom_range(1) ? 16'($urandom) : 16'd0;
      // now and then spoil one field so the token misses
      if ($urandom_range(9) == 0) begin
         b = $urandom_range(15);
         case ($urandom_range(5))
            0: w.prog_ident[b] = ~w.prog_ident[b];
            1: w.gen_in[b] = ~w.gen_in[b];
            2: w.step_ident[b] = ~w.step_ident[b];
            3: w.req_in[b] = ~w.req_in[b];
            4: w.kind_in[b % 8] = ~w.kind_in[b % 8];
            default: w.token_kind_in = w.token_kind_in + 2'd1;
         endcase
      end
      return w;
   endfunction

   function automatic req_item_type pick_word();
      req_item_type w;
      int r;
      w = rand_word();
      r = $urandom_range(99);
      if (r < 12) begin
         // noise; keep away from the stuck wait-phase abort
         if ((exec_phase == PH_WLOAD || exec_phase == PH_WUNLOAD) && w.operation == OP_ABORT)
            w.operation = OP_LOAD_STEP;
         return w;
      end
      w.token_kind_in = 2'($urandom_range(2));
      case (exec_phase)
         PH_IDLE: begin
            if (r < 30) begin
               w.operation = OP_LOAD_STEP;
               w.kind_in = pick_step_kind();
            end else begin
               w.operation = OP_ACCEPT;
            end
         end
         PH_FAULT: w.operation = OP_FAULT_ACK;
         PH_DISP: begin
            if (r < 75) w.operation = OP_DISP_OK;
            else if (r < 85) w.operation = OP_DISP_FAIL;
            else if (r < 93) w.operation = OP_CANCEL;
            else w.operation = OP_ABORT;
         end
         PH_ACTIVE: begin
            if (r < 70) w = terminal_for(tokens[TS_ACT], w);
            else if (r < 80) w.operation = OP_TIMEOUT;
            else if (r < 88) w.operation = OP_SKIP;
            else if (r < 94) w.operation = OP_CANCEL;
            else w.operation = OP_ABORT;
         end
         PH_CANCEL: w = terminal_for(tokens[TS_CAN], w);
         PH_RESET: w = terminal_for(tokens[TS_RST], w);
         PH_WLOAD: w.operation = (r < 90) ? OP_LOAD_OK : OP_UNLOAD_OK;
         default: w.operation = (r < 90) ? OP_UNLOAD_OK : OP_LOAD_OK;
      endcase
      return w;
   endfunction

   task automatic send_word(req_item_type w);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         if (req_up) begin
            req.valid <= 1'b0;
            req_up = 0;
         end
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= w;
      req_up = 1;
      do @(posedge clock); while (!req.ready);
      predict_word(w);
   endtask

   task automatic drain();
      if (req_up) begin
         req.valid <= 1'b0;
         req_up = 0;
      end
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [15:0] value);
      csr.valid <= 1'b1;
      csr.data <= '{addr: addr, wdata: value};
      do @(posedge clock); while (!csr.ready);
      if (addr == CSR_STEP_COUNT) cfg_count = value[4:0];
      else if (addr == CSR_QUIESCE) cfg_quiesce = value[0];
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_slot(int s, logic [15:0] id, logic [7:0] kind);
      req_item_type w;
      w = rand_word();
      w.operation = OP_LOAD_STEP;
      w.slot = 4'(s);
      w.step_ident = id;
      w.kind_in = kind;
      send_word(w);
   endtask

   task automatic accept_prog(logic [15:0] prog);
      req_item_type w;
      w = rand_word();
      w.operation = OP_ACCEPT;
      w.prog_ident = prog;
      send_word(w);
   endtask

   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= rsp_stall);
   end

   always @(posedge clock) begin
      string why;
      if (!reset && rsp.valid && rsp.ready) begin
         why = sb.check_cmd(rsp.data);
         if (why != "") report(why);
      end
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      logic [4:0] count_opts [6];
      req_item_type w;
      int tries;
      count_opts = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd4};
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      foreach (tokens[i]) tokens[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table before any program reads it
      load_slot(0, 16'h0000, SK_UV);
      load_slot(1, 16'hFFFF, 8'd255);
      load_slot(2, 16'h1234, SK_WLOAD);
      load_slot(3, 16'h8001, SK_WUNLOAD);
      load_slot(4, 16'h00FF, 8'd4);
      load_slot(5, 16'h5A5A, SK_FINISH);
      for (int s = 6; s < SPE_MAX_STEPS; s++) load_slot(s, 16'($urandom), pick_step_kind());
      accept_prog(16'hFFFF);
      drain();
      csr_write(CSR_QUIESCE, 16'd1);
      accept_prog(16'h0001);
      drain();
      csr_write(CSR_QUIESCE, 16'd0);
      csr_write(CSR_STEP_COUNT, 16'd6);
      accept_prog(16'h0000);
      repeat (5) send_word(pick_word());

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle = 0; rsp_stall = 0; end
            1: begin send_idle = 48; rsp_stall = 0; end
            2: begin send_idle = 0; rsp_stall = 48; end
            default: begin send_idle = 27; rsp_stall = 27; end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            drain();
            csr_write(CSR_STEP_COUNT,
                      $urandom_range(2) == 0 ? 16'($urandom_range(31))
                                             : {11'd0, count_opts[$urandom_range(5)]});
            csr_write(CSR_QUIESCE, 16'($urandom_range(5) == 0));
            repeat (70) send_word(pick_word());
         end
      end

      // abort from a wait phase parks the executor; do it last
      drain();
      csr_write(CSR_QUIESCE, 16'd0);
      csr_write(CSR_STEP_COUNT, 16'd16);
      load_slot(0, 16'h0042, SK_WLOAD);
      tries = 0;
      while (exec_phase != PH_WLOAD && exec_phase != PH_WUNLOAD && tries < 300) begin
         send_word(pick_word());
         tries++;
      end
      if (exec_phase == PH_WLOAD || exec_phase == PH_WUNLOAD) begin
         w = rand_word();
         w.operation = OP_ABORT;
         send_word(w);
         send_word(terminal_for(tokens[TS_CAN], w));
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.pending.size() > 0) report($sformatf("%0d commands never came", sb.pending.size()));
      if (fails == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
